// ----- hdl/psfc_pkg.sv -----
`default_nettype none

package psfc_pkg;

  // Flash window and sector geometry
  localparam logic [31:0] FLASH_BASE         = 32'h0800_0000;
  localparam int          SMALL_SECTOR_SHIFT = 14;  // 16 KiB sectors 0..3
  localparam int          LARGE_SECTOR_SHIFT = 17;  // 128 KiB sectors from 5 up
  localparam int          PERM_SECTORS       = 12;  // sectors covered by the permission word
  localparam int          PERM_W             = 24;
  localparam int          SECTOR_W           = 4;
  localparam int          CFG_IDX_W          = 1;
  localparam int          CFG_DATA_W         = 24;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUPERVISOR_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_PERMISSIONS = 1'd1;

  localparam logic                 SUPERVISOR_RESET  = 1'b1;
  localparam logic [PERM_W-1:0]    PERMISSIONS_RESET = 24'h55_5552;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DENIED  = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_MEM,
    S_ERASE,
    S_FIN
  } state_t;

  // Decoder verdict for the item held in the top level
  typedef struct packed {
    logic                go_mem;
    logic                go_erase;
    status_t             status;
    logic                has_sector;
    logic [SECTOR_W-1:0] found;
  } decode_t;

  // Byte offset of the start of sector i from the flash base
  function automatic logic [31:0] sector_start(input logic [4:0] i);
    logic [31:0] r;
    if (i <= 5'd4) begin
      r = 32'(i) << SMALL_SECTOR_SHIFT;
    end else begin
      r = 32'(i - 5'd4) << LARGE_SECTOR_SHIFT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/psfc_if.sv -----
`default_nettype none

// Command channel
interface psfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [3:0]  sector_index;

  modport source (output valid, cmd, address, write_data, sector_index, input ready);
  modport sink   (input valid, cmd, address, write_data, sector_index, output ready);
endinterface

// Result channel
interface psfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [3:0]  sector_found;
  logic [31:0] wear_value;

  modport source (output valid, status, read_data, sector_found, wear_value, input ready);
  modport sink   (input valid, status, read_data, sector_found, wear_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/psfc_decode.sv -----
`default_nettype none

module psfc_decode #(
  parameter int SECTOR_COUNT = 12,
  parameter int FLASH_WORDS  = 262144
) (
  input  wire logic [1:0]                       cmd,
  input  wire logic [31:0]                      address,
  input  wire logic [3:0]                       sector_index,
  input  wire logic                             supervisor,
  input  wire logic [psfc_pkg::PERM_W-1:0]      permissions,
  output psfc_pkg::decode_t                     dec,
  output logic [$clog2(FLASH_WORDS)-1:0]        widx,
  output logic [$clog2(FLASH_WORDS+1)-1:0]      erase_lo,
  output logic [$clog2(FLASH_WORDS+1)-1:0]      erase_hi
);
  import psfc_pkg::*;

  localparam int          AW          = $clog2(FLASH_WORDS);
  localparam int          PW          = $clog2(FLASH_WORDS + 1);
  localparam logic [31:0] SEC_END     = sector_start(5'(SECTOR_COUNT));
  localparam logic [31:0] FLASH_BYTES = 32'(FLASH_WORDS * 4);
  localparam logic [31:0] MAP_END     = (SEC_END < FLASH_BYTES) ? SEC_END : FLASH_BYTES;
  localparam logic [31:0] WORDS32     = 32'(FLASH_WORDS);

  logic [31:0]         off;
  logic                in_map;
  logic [SECTOR_W-1:0] rw_sec;
  logic [SECTOR_W-1:0] psec;
  logic [15:0]         perm_nz;
  logic                allowed;
  logic                sidx_ok;
  logic [31:0]         lo_w, hi_w, hi_c, lo_c;

  // Address window and sector lookup
  always_comb begin
    off    = address - FLASH_BASE;
    in_map = (address >= FLASH_BASE) && (off < MAP_END);
    rw_sec = '0;
    for (int i = 1; i < SECTOR_COUNT; i++) begin
      if (off >= sector_start(5'(i))) rw_sec = SECTOR_W'(i);
    end
  end

  // Permission check; sectors beyond the permission word are read-only
  always_comb begin
    perm_nz = '0;
    for (int j = 0; j < PERM_SECTORS; j++) begin
      perm_nz[j] = |permissions[2*j +: 2];
    end
    psec    = (cmd == CMD_ERASE) ? sector_index : rw_sec;
    allowed = supervisor | perm_nz[psec];
    sidx_ok = {1'b0, sector_index} < 5'(SECTOR_COUNT);
  end

  // Erase word range, clipped to the store
  always_comb begin
    lo_w     = sector_start({1'b0, sector_index}) >> 2;
    hi_w     = sector_start({1'b0, sector_index} + 5'd1) >> 2;
    hi_c     = (hi_w < WORDS32) ? hi_w : WORDS32;
    lo_c     = (lo_w < hi_c) ? lo_w : hi_c;
    erase_lo = lo_c[PW-1:0];
    erase_hi = hi_c[PW-1:0];
    widx     = off[AW+1:2];
  end

  // Verdict
  always_comb begin
    dec        = '0;
    dec.status = ST_OK;
    case (cmd)
      CMD_READ, CMD_WRITE: begin
        if (address[1:0] != 2'b00) begin
          dec.status = ST_INVALID;
        end else if (!in_map) begin
          dec.status = (cmd == CMD_READ) ? ST_FAILED : ST_INVALID;
        end else begin
          dec.has_sector = 1'b1;
          dec.found      = rw_sec;
          if (cmd == CMD_READ || allowed) begin
            dec.go_mem = 1'b1;
          end else begin
            dec.status = ST_DENIED;
          end
        end
      end
      CMD_ERASE: begin
        if (!sidx_ok) begin
          dec.status = ST_INVALID;
        end else begin
          dec.has_sector = 1'b1;
          dec.found      = sector_index;
          if (allowed) begin
            dec.go_erase = 1'b1;
          end else begin
            dec.status = ST_DENIED;
          end
        end
      end
      default: begin
        dec.status = ST_INVALID;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/protected_sector_flash_controller.sv -----
`default_nettype none

// Emulated flash with a non-uniform sector map at 0x08000000 and a wear
// count per sector.
// in_chan carries one command item (read word, write word, erase sector);
// out_chan returns exactly one result item per command, in order.
// cfg_we/cfg_index/cfg_wdata write supervisor_mode (index 0) and
// sector_permissions (index 1); writes are taken in any cycle.
// Word read or write: accept, decode and flash read, check and program,
// result load, the steps of the read-modify-write of the flash array. An
// item rejected at decode (bad address, bad sector index, denied, unused
// code) skips the flash steps: accept, decode, result load. Erase: accept,
// decode, then the N words of the sector (4096 or 16384 or 32768), one word
// written per cycle, then the wear count update and the result load.
// A new item is taken once the previous result is loaded into the output
// register, even while that result waits for out_chan.ready. If the
// receiver still holds the previous result when the next one is ready,
// the block waits in its final state and takes no input.
// After reset a clearing pass writes all ones to FLASH_WORDS words, one per
// cycle; in_chan.ready stays low meanwhile.
// Wear counts reset to zero at once.
module protected_sector_flash_controller #(
  parameter int SECTOR_COUNT = 12,
  parameter int FLASH_WORDS  = 262144
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  psfc_in_if.sink                                 in_chan,
  psfc_out_if.source                              out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [psfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import psfc_pkg::*;

  localparam int AW = $clog2(FLASH_WORDS);
  localparam int PW = $clog2(FLASH_WORDS + 1);
  localparam int SW = $clog2(SECTOR_COUNT);
  localparam logic [PW-1:0] LAST_WORD = PW'(FLASH_WORDS - 1);

  // Configuration
  logic              sup_r;
  logic [PERM_W-1:0] perm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r  <= SUPERVISOR_RESET;
      perm_r <= PERMISSIONS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUPERVISOR_MODE:    sup_r  <= cfg_wdata[0];
        REG_SECTOR_PERMISSIONS: perm_r <= cfg_wdata[PERM_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  state_t              state_r, state_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic [PW-1:0]       end_r, end_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          cmd_r;
  logic [31:0]         addr_r, wdata_r;
  logic [3:0]          sidx_r;
  status_t             res_status_r, res_status_nxt;
  logic [31:0]         res_rdata_r, res_rdata_nxt;
  logic [SECTOR_W-1:0] res_found_r, res_found_nxt;
  logic                res_has_r, res_has_nxt;
  status_t             out_status_r;
  logic [31:0]         out_rdata_r, out_wear_r;
  logic [SECTOR_W-1:0] out_found_r;
  logic [31:0]         wear_r [SECTOR_COUNT];
  logic                in_fire, out_load, wear_inc;
  logic [SW-1:0]       wear_idx;

  // Flash array
  logic [31:0]   mem [FLASH_WORDS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata_r;

  // Decoder
  decode_t       dec;
  logic [AW-1:0] widx;
  logic [PW-1:0] erase_lo, erase_hi;

  psfc_decode #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .FLASH_WORDS  (FLASH_WORDS)
  ) u_decode (
    .cmd          (cmd_r),
    .address      (addr_r),
    .sector_index (sidx_r),
    .supervisor   (sup_r),
    .permissions  (perm_r),
    .dec          (dec),
    .widx         (widx),
    .erase_lo     (erase_lo),
    .erase_hi     (erase_hi)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && (state_r == S_IDLE);
  assign wear_idx      = res_found_r[SW-1:0];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_found_nxt  = res_found_r;
    res_has_nxt    = res_has_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = widx;
    mem_wdata      = '1;
    out_load       = 1'b0;
    wear_inc       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        if (ptr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      S_IDLE: begin
        if (in_chan.valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        res_status_nxt = dec.status;
        res_has_nxt    = dec.has_sector;
        res_found_nxt  = dec.found;
        res_rdata_nxt  = '0;
        if (dec.go_mem) begin
          mem_re    = 1'b1;
          state_nxt = S_MEM;
        end else if (dec.go_erase) begin
          ptr_nxt   = erase_lo;
          end_nxt   = erase_hi;
          state_nxt = S_ERASE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MEM: begin
        // word is programmable only while still erased
        if (cmd_r == CMD_READ) begin
          res_rdata_nxt = mem_rdata_r;
        end else if (mem_rdata_r != '1) begin
          res_status_nxt = ST_FAILED;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = wdata_r;
        end
        state_nxt = S_FIN;
      end
      S_ERASE: begin
        if (ptr_r >= end_r) begin
          wear_inc  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ptr_r[AW-1:0];
          ptr_nxt   = ptr_r + PW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Wear counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTOR_COUNT; i++) wear_r[i] <= '0;
    end else if (wear_inc) begin
      wear_r[wear_idx] <= wear_r[wear_idx] + 32'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_chan.cmd;
      addr_r  <= in_chan.address;
      wdata_r <= in_chan.write_data;
      sidx_r  <= in_chan.sector_index;
    end
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_found_r  <= res_found_nxt;
    res_has_r    <= res_has_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rdata_r  <= res_rdata_r;
      out_found_r  <= res_has_r ? res_found_r : '0;
      out_wear_r   <= res_has_r ? wear_r[wear_idx] : '0;
    end
  end

  // Flash array ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[widx];
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.read_data    = out_rdata_r;
  assign out_chan.sector_found = out_found_r;
  assign out_chan.wear_value   = out_wear_r;

  // Checks
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !$rose(out_valid_r))
    else $error("result appeared one cycle after accept");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !mem_we)
    else $error("flash written outside a write or erase");

  a_erase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERASE) |-> (ptr_r <= end_r))
    else $error("erase pointer ran past sector end");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_chan.ready) |=> (state_r == S_FIN))
    else $error("result overwrote a pending output item");

endmodule

`default_nettype wire
